// File: sv/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg: shared types and constants of the MSB-first bit packer
// Beat formats, the queue entry passed from the front to the back, and sizes.
// ----------------------------------------------------------------------------
package mbp_pkg;

   localparam int BYTE_BITS   = 8;
   localparam int FIELD_BITS  = 64;
   localparam int COUNT_BITS  = 7;
   localparam int MAX_WIDTH   = 64;
   localparam int STREAM_BITS = FIELD_BITS + BYTE_BITS;
   localparam int PEND_BITS   = 4;
   localparam int BYTES_BITS  = 4;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_ALIGN  = 1'b1;

   typedef struct packed {
      logic                  operation;
      logic [COUNT_BITS-1:0] bit_count;
      logic [FIELD_BITS-1:0] field_value;
   } req_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 last_of_run;
   } rsp_type;

   // Right-justified bit stream of one item, its length and its byte count.
   typedef struct packed {
      logic [STREAM_BITS-1:0] stream;
      logic [COUNT_BITS-1:0]  total;
      logic [BYTES_BITS-1:0]  count;
   } entry_type;

endpackage

// File: sv/mbp_front.sv
// ----------------------------------------------------------------------------
// mbp_front: request front end
// Holds the pending byte, accepts requests and turns each one that sends
// bytes into a queue entry for the back end.
// ----------------------------------------------------------------------------
module mbp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  mbp_pkg::req_type   req_item,
   output logic               q_push,
   output mbp_pkg::entry_type q_entry,
   input  logic               q_full
);

   logic [mbp_pkg::BYTE_BITS-1:0]   pbits_ff, pbits_in;
   logic [mbp_pkg::PEND_BITS-1:0]   pcnt_ff, pcnt_in;

   logic                             accept;
   logic [mbp_pkg::COUNT_BITS-1:0]   width;
   logic [mbp_pkg::FIELD_BITS-1:0]   vmask;
   logic [mbp_pkg::STREAM_BITS-1:0]  stream_app;
   logic [mbp_pkg::COUNT_BITS-1:0]   total_app;
   logic [mbp_pkg::COUNT_BITS-1:0]   total_m1;
   logic [mbp_pkg::PEND_BITS-1:0]    rem;
   logic [mbp_pkg::BYTES_BITS-1:0]   count_app;
   logic [mbp_pkg::BYTE_BITS-1:0]    align_byte;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   always_comb begin
      if (req_item.bit_count > mbp_pkg::COUNT_BITS'(mbp_pkg::MAX_WIDTH)) begin
         width = mbp_pkg::COUNT_BITS'(mbp_pkg::MAX_WIDTH);
      end else begin
         width = req_item.bit_count;
      end
   end

   // The pending bits followed by the new field form one stream of total_app
   // bits; all whole bytes but the last are sent, unless a partly filled
   // pending byte is topped off exactly, in which case nothing stays behind.
   assign vmask      = req_item.field_value & ~({mbp_pkg::FIELD_BITS{1'b1}} << width);
   assign stream_app = ({{(mbp_pkg::STREAM_BITS - mbp_pkg::BYTE_BITS){1'b0}}, pbits_ff}
                        << width) | {{mbp_pkg::BYTE_BITS{1'b0}}, vmask};
   assign total_app  = {{(mbp_pkg::COUNT_BITS - mbp_pkg::PEND_BITS){1'b0}}, pcnt_ff} + width;
   assign total_m1   = total_app - 7'd1;

   always_comb begin
      if (pcnt_ff != '0 && total_app == mbp_pkg::COUNT_BITS'(mbp_pkg::BYTE_BITS)) begin
         rem = '0;
      end else begin
         rem = {1'b0, total_m1[2:0]} + 4'd1;
      end
   end

   assign count_app  = mbp_pkg::BYTES_BITS'(
      (total_app - {{(mbp_pkg::COUNT_BITS - mbp_pkg::PEND_BITS){1'b0}}, rem}) >> 3);
   assign align_byte = pbits_ff << (mbp_pkg::PEND_BITS'(mbp_pkg::BYTE_BITS) - pcnt_ff);

   always_comb begin
      pbits_in = pbits_ff;
      pcnt_in  = pcnt_ff;
      q_entry  = '0;
      case (req_item.operation)
         mbp_pkg::OP_ALIGN: begin
            q_entry.stream = {{(mbp_pkg::STREAM_BITS - mbp_pkg::BYTE_BITS){1'b0}}, align_byte};
            q_entry.total  = mbp_pkg::COUNT_BITS'(mbp_pkg::BYTE_BITS);
            q_entry.count  = (pcnt_ff != '0) ? 4'd1 : 4'd0;
            if (accept) begin
               pbits_in = '0;
               pcnt_in  = '0;
            end
         end
         mbp_pkg::OP_APPEND: begin
            q_entry.stream = stream_app;
            q_entry.total  = total_app;
            if (width != '0) begin
               q_entry.count = count_app;
               if (accept) begin
                  pbits_in = stream_app[mbp_pkg::BYTE_BITS-1:0] & ~(8'hff << rem);
                  pcnt_in  = rem;
               end
            end
         end
         default: begin
            q_entry = '0;
         end
      endcase
   end

   assign q_push = accept && (q_entry.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pbits_ff <= '0;
         pcnt_ff  <= '0;
      end else begin
         pbits_ff <= pbits_in;
         pcnt_ff  <= pcnt_in;
      end
   end

endmodule

// File: sv/mbp_queue.sv
// ----------------------------------------------------------------------------
// mbp_queue: entry queue between front and back end
// A short first-in first-out queue of pending work entries.
// ----------------------------------------------------------------------------
module mbp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_push,
   input  mbp_pkg::entry_type q_wdata,
   output logic               q_full,
   input  logic               q_pop,
   output mbp_pkg::entry_type q_rdata,
   output logic               q_empty
);

   mbp_pkg::entry_type                   slot_ff [mbp_pkg::QUEUE_DEPTH];
   logic [mbp_pkg::QUEUE_PTR_BITS-1:0]   wptr_ff, wptr_in;
   logic [mbp_pkg::QUEUE_PTR_BITS-1:0]   rptr_ff, rptr_in;
   logic [mbp_pkg::QUEUE_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                                 do_push;
   logic                                 do_pop;

   assign q_full  = (cnt_ff == mbp_pkg::QUEUE_CNT_BITS'(mbp_pkg::QUEUE_DEPTH));
   assign q_empty = (cnt_ff == '0);
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;
   assign q_rdata = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (do_push) begin
         if (wptr_ff == mbp_pkg::QUEUE_PTR_BITS'(mbp_pkg::QUEUE_DEPTH - 1)) begin
            wptr_in = '0;
         end else begin
            wptr_in = wptr_ff + 1'b1;
         end
      end
      if (do_pop) begin
         if (rptr_ff == mbp_pkg::QUEUE_PTR_BITS'(mbp_pkg::QUEUE_DEPTH - 1)) begin
            rptr_in = '0;
         end else begin
            rptr_in = rptr_ff + 1'b1;
         end
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= q_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// File: sv/mbp_back.sv
// ----------------------------------------------------------------------------
// mbp_back: byte sender
// Sends each queue entry's bytes in turn, one per cycle while rsp_pop is high.
// ----------------------------------------------------------------------------
module mbp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   output logic               q_pop,
   input  mbp_pkg::entry_type q_entry,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output mbp_pkg::rsp_type   rsp_item
);

   logic                             busy_ff, busy_in;
   logic [mbp_pkg::STREAM_BITS-1:0]  stream_ff, stream_in;
   logic [mbp_pkg::BYTES_BITS-1:0]   left_ff, left_in;

   logic                             take;
   logic                             finishing;
   logic                             load;
   logic [mbp_pkg::COUNT_BITS-1:0]   lsh;

   assign rsp_empty = !busy_ff;
   assign take      = busy_ff && rsp_pop;
   assign finishing = take && (left_ff == 4'd1);
   assign load      = !q_empty && (!busy_ff || finishing);
   assign q_pop     = load;

   // Left-justify the stream so the next byte always sits in the top bits.
   assign lsh = mbp_pkg::COUNT_BITS'(mbp_pkg::STREAM_BITS) - q_entry.total;

   always_comb begin
      busy_in   = busy_ff;
      stream_in = stream_ff;
      left_in   = left_ff;
      if (load) begin
         busy_in   = 1'b1;
         stream_in = q_entry.stream << lsh;
         left_in   = q_entry.count;
      end else if (take) begin
         stream_in = stream_ff << mbp_pkg::BYTE_BITS;
         left_in   = left_ff - 4'd1;
         if (finishing) begin
            busy_in = 1'b0;
         end
      end
   end

   assign rsp_item.out_byte    = stream_ff[mbp_pkg::STREAM_BITS-1 -: mbp_pkg::BYTE_BITS];
   assign rsp_item.last_of_run = (left_ff == 4'd1);

   always_ff @(posedge clock) begin
      stream_ff <= stream_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         left_ff <= left_in;
      end
   end

endmodule

// File: sv/msb_first_bit_packer_core.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer_core: MSB-first variable-length bit packer
// Packs fields of 1 to 64 bits, most significant bit first, into bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on a queue-style port: a beat is taken when req_push is
//   high and req_full is low. An append beat adds the low bit_count bits of
//   field_value (counts above 64 act as 64, zero does nothing); an align beat
//   pads the pending bits with zeros and sends them as one byte.
//   Bytes leave on a queue-style port: the oldest byte is on rsp_item while
//   rsp_empty is low and is taken when rsp_pop is high. last_of_run marks the
//   final byte caused by one request.
//   With the sender idle, the first byte of a request passes through the
//   queue slot and the sender's stream register before it is on rsp_item.
//   Throughput: the byte sender emits one byte per cycle while the receiver
//   pops; a request sends 0 to 8 bytes.
//   A two-entry queue sits between the front end and the sender; when the
//   receiver stalls the queue fills and req_full rises.
//   Reset clears the pending byte, the queue and the sender.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  mbp_pkg::req_type req_item,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output mbp_pkg::rsp_type rsp_item
);

   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_empty;
   mbp_pkg::entry_type q_wdata;
   mbp_pkg::entry_type q_rdata;

   mbp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_push   (q_push),
      .q_entry  (q_wdata),
      .q_full   (q_full)
   );

   mbp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_rdata (q_rdata),
      .q_empty (q_empty)
   );

   mbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_entry   (q_rdata),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

`ifndef SYNTH
   // A waiting entry is picked up by an idle sender at once.
   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_empty && !q_empty) |=> !rsp_empty)
      else $error("idle sender did not pick up a queued entry");

   // More bytes of the same request follow a beat that is not the last one.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_item.last_of_run) |=> !rsp_empty)
      else $error("byte run ended before its last beat");

   // Every queued entry carries one to eight bytes.
   a_entry_count: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_wdata.count != '0 && q_wdata.count <= 4'd8))
      else $error("queued entry has a bad byte count");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the MSB-first bit packer core
// Offers append and align beats in bursts, predicts every packed byte and
// checks each popped byte against the oldest prediction while the receiver
// stalls on patterns of its own, including one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import mbp_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_OFF     = 150;
   localparam int CHUNK_ITEMS  = 80;
   localparam int DRAIN_CYCLES = 20;

   typedef enum int {POP_ALWAYS, POP_RANDOM, POP_PATTERN} pop_style_type;

   logic    clock;
   logic    reset;
   logic    req_push;
   logic    req_full;
   req_type req_item;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_item;

   // Predicted packer state and the bytes still owed by the block.
   logic [BYTE_BITS-1:0] held_bits;
   logic [PEND_BITS-1:0] held_count;
   rsp_type              byte_queue[$];

   int            error_count;
   int            burst_left;
   bit            gaps_on;
   pop_style_type pop_style;
   int            hold_cycles;

   msb_first_bit_packer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [BYTE_BITS-1:0] low_bits(logic [FIELD_BITS-1:0] value, int width);
      logic [FIELD_BITS-1:0] mask;
      mask = (64'd1 << width) - 64'd1;
      return value[BYTE_BITS-1:0] & mask[BYTE_BITS-1:0];
   endfunction

   // Works out the bytes that one accepted beat causes and queues them.
   task automatic pack_bits(input req_type beat_in);
      rsp_type               run[$];
      rsp_type               one;
      int                    width;
      int                    fill;
      logic [FIELD_BITS-1:0] top;
      logic [FIELD_BITS-1:0] wide;
      width = beat_in.bit_count;
      one.last_of_run = 1'b0;
      if (beat_in.operation == OP_ALIGN) begin
         if (held_count != 0) begin
            wide = 64'(held_bits) << (BYTE_BITS - held_count);
            one.out_byte = wide[BYTE_BITS-1:0];
            run.push_back(one);
         end
         held_bits = '0;
         held_count = '0;
      end else begin
         if (width > MAX_WIDTH) width = MAX_WIDTH;
         if (width != 0 && held_count != 0) begin
            if (held_count + width < BYTE_BITS) begin
               wide = (64'(held_bits) << width) | 64'(low_bits(beat_in.field_value, width));
               held_bits = wide[BYTE_BITS-1:0];
               held_count = held_count + width;
               width = 0;
            end else begin
               // Top up the held byte from the most significant new bits.
               fill = BYTE_BITS - held_count;
               width -= fill;
               top = (width < FIELD_BITS) ? beat_in.field_value >> width : '0;
               wide = (64'(held_bits) << fill) | 64'(low_bits(top, fill));
               one.out_byte = wide[BYTE_BITS-1:0];
               run.push_back(one);
               held_bits = '0;
               held_count = '0;
            end
         end
         while (width > BYTE_BITS) begin
            width -= BYTE_BITS;
            wide = beat_in.field_value >> width;
            one.out_byte = wide[BYTE_BITS-1:0];
            run.push_back(one);
         end
         // A full byte stays held here until more bits or an align arrive.
         if (width != 0) begin
            held_bits = low_bits(beat_in.field_value, width);
            held_count = width;
         end
      end
      if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
      foreach (run[i]) byte_queue.push_back(run[i]);
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_beat(input logic op, input int count, input logic [FIELD_BITS-1:0] value);
      req_type beat_out;
      int      gap;
      beat_out.operation = op;
      beat_out.bit_count = 7'(count);
      beat_out.field_value = value;
      if (gaps_on) begin
         if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
               req_push <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
      end
      req_item <= beat_out;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      pack_bits(beat_out);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (byte_queue.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_phase(input pop_style_type style, input bit gaps);
      @(posedge clock);
      pop_style = style;
      gaps_on = gaps;
      burst_left = 0;
      @(negedge clock);
   endtask

   task automatic test_special_cases();
      set_phase(POP_ALWAYS, 1'b0);
      send_beat(OP_ALIGN, 64, '1);
      send_beat(OP_APPEND, 0, '1);
      send_beat(OP_APPEND, 64, '1);
      // Eight bits are held now, so this beat first flushes them.
      send_beat(OP_APPEND, 1, '0);
      send_beat(OP_ALIGN, $urandom_range(0, 127), {$urandom(), $urandom()});
      send_beat(OP_APPEND, 127, {$urandom(), $urandom()});
      send_beat(OP_APPEND, 65, {$urandom(), $urandom()});
      send_beat(OP_APPEND, 100, {$urandom(), $urandom()});
      send_beat(OP_ALIGN, 0, '0);
      wait_drained();
   endtask

   task automatic test_wide_fields();
      set_phase(POP_RANDOM, 1'b1);
      send_beat(OP_APPEND, 64, '0);
      send_beat(OP_APPEND, 64, {$urandom(), $urandom()});
      send_beat(OP_APPEND, 8, 64'hA5);
      send_beat(OP_APPEND, 9, {$urandom(), $urandom()});
      send_beat(OP_APPEND, 63, {$urandom(), $urandom()});
      send_beat(OP_ALIGN, 127, '1);
      wait_drained();
   endtask

   task automatic test_partial_bytes();
      set_phase(POP_PATTERN, 1'b1);
      send_beat(OP_APPEND, 3, {$urandom(), $urandom()});
      send_beat(OP_APPEND, 2, {$urandom(), $urandom()});
      send_beat(OP_APPEND, 3, {$urandom(), $urandom()});
      send_beat(OP_APPEND, 7, {$urandom(), $urandom()});
      send_beat(OP_APPEND, 1, '1);
      send_beat(OP_APPEND, 1, '1);
      send_beat(OP_ALIGN, 1, '1);
      send_beat(OP_APPEND, 5, {$urandom(), $urandom()});
      send_beat(OP_ALIGN, 5, '0);
      wait_drained();
   endtask

   // The receiver holds off while full-width beats keep coming, so the
   // internal queue fills and the input stalls.
   task automatic test_backpressure();
      set_phase(POP_ALWAYS, 1'b0);
      @(posedge clock);
      hold_cycles = HOLD_OFF;
      @(negedge clock);
      repeat (16) send_beat(OP_APPEND, 64, {$urandom(), $urandom()});
      wait_drained();
   endtask

   task automatic test_random_mix();
      int pick;
      int count;
      logic op;
      for (int chunk = 0; chunk < 4; chunk++) begin
         case (chunk)
            0: set_phase(POP_RANDOM, 1'b1);
            1: set_phase(POP_ALWAYS, 1'b0);
            2: set_phase(POP_PATTERN, 1'b1);
            default: set_phase(POP_RANDOM, 1'b0);
         endcase
         repeat (CHUNK_ITEMS) begin
            pick = $urandom_range(0, 99);
            op = OP_APPEND;
            if (pick < 8) begin
               op = OP_ALIGN;
               count = $urandom_range(0, 127);
            end else if (pick < 12) begin
               count = 0;
            end else if (pick < 17) begin
               count = $urandom_range(65, 127);
            end else if (pick < 55) begin
               count = $urandom_range(1, 9);
            end else begin
               count = $urandom_range(1, 64);
            end
            send_beat(op, count, {$urandom(), $urandom()});
         end
         wait_drained();
      end
   endtask

   initial begin : receiver
      int run_left;
      bit stalled;
      run_left = 0;
      stalled = 1'b0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_pop <= 1'b0;
         end else begin
            case (pop_style)
               POP_ALWAYS: rsp_pop <= 1'b1;
               POP_RANDOM: rsp_pop <= ($urandom_range(0, 99) >= 35);
               default: begin
                  // Alternate runs of pops and stalls of random length.
                  if (run_left == 0) begin
                     stalled = !stalled;
                     run_left = stalled ? $urandom_range(1, 5) : $urandom_range(1, 9);
                  end
                  run_left--;
                  rsp_pop <= !stalled;
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin : byte_check
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (byte_queue.size() == 0) begin
            $error("unexpected beat: out_byte %h last_of_run %b",
                   rsp_item.out_byte, rsp_item.last_of_run);
            error_count++;
         end else begin
            want = byte_queue.pop_front();
            if (rsp_item.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, actual %h", want.out_byte, rsp_item.out_byte);
               error_count++;
            end
            if (rsp_item.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %b, actual %b",
                      want.last_of_run, rsp_item.last_of_run);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("msb_first_bit_packer_core: mismatch");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_item = '0;
      error_count = 0;
      burst_left = 0;
      gaps_on = 1'b0;
      pop_style = POP_ALWAYS;
      hold_cycles = 0;
      held_bits = '0;
      held_count = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_special_cases();
      test_wide_fields();
      test_partial_bytes();
      test_backpressure();
      test_random_mix();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (byte_queue.size() != 0) begin
         $error("%0d expected beats never arrived", byte_queue.size());
         error_count++;
      end
      if (error_count == 0) $display("msb_first_bit_packer_core: match");
      else $display("msb_first_bit_packer_core: mismatch");
      $finish;
   end

endmodule

// File: files.f
sv/mbp_pkg.sv
sv/mbp_front.sv
sv/mbp_queue.sv
sv/mbp_back.sv
sv/msb_first_bit_packer_core.sv
bench/testbench.sv
